// ===== rtl/rdq_pkg.sv =====
// Shared constants and register map for the row dynamic int8 quantizer.
package rdq_pkg;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register index, taken from paddr[2]
   localparam logic CSR_ROW_LENGTH = 1'b0;
   localparam logic CSR_ROW_COUNT  = 1'b1;

   localparam int LEN_BITS   = 7;
   localparam int ROWS_BITS  = 16;
   localparam int QUANT_BITS = 8;
   localparam int PEAK_BITS  = 16;
   localparam int QUOT_BITS  = 7;

   localparam logic [LEN_BITS-1:0]   ROW_LENGTH_RESET = 7'd64;
   localparam logic [ROWS_BITS-1:0]  ROW_COUNT_RESET  = 16'd1;
   localparam logic [QUANT_BITS-1:0] MID_CODE         = 8'd128;

endpackage

// ===== rtl/rdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rdq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/row_dynamic_int8_quantizer_core.sv =====
// Per-row dynamic symmetric quantizer: row buffer, peak tracking, shared restoring divider.
// Samples load at one item per cycle while collecting; the item that ends a row starts emission.
// Each result passes through RAM read, operand load, 7 divide steps and emit, plus any
//   stall on rsp_tready; req_tready stays low until the last result of the row is emitted.
// The result register lets the next result be computed while the previous one waits.
// Synchronous reset clears control state and sets row_length to 64, row_count to 1.
module row_dynamic_int8_quantizer_core #(
   parameter int ROW_MAX     = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,   // [SAMPLE_BITS-1:0] sample
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [23:0]                            rsp_tdata,   // [7:0] quant_byte, [23:8] row_peak
   output logic                                   rsp_tlast,   // row_last
   output logic                                   rsp_tuser,   // matrix_last
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [rdq_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [rdq_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [rdq_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                   csr_pready
);

   localparam int IDX_W = $clog2(ROW_MAX);
   localparam int CNT_W = $clog2(ROW_MAX + 1);
   localparam int NUM_W = SAMPLE_BITS + 8;
   localparam int QB    = rdq_pkg::QUOT_BITS;

   typedef enum logic [2:0] {
      S_COLLECT,
      S_READ,
      S_LOAD,
      S_DIV,
      S_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [rdq_pkg::LEN_BITS-1:0]      row_length_ff, row_length_in;
   logic [rdq_pkg::ROWS_BITS-1:0]     row_count_ff, row_count_in;
   logic [rdq_pkg::ROWS_BITS-1:0]     row_idx_ff, row_idx_in;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic [IDX_W-1:0]                  last_k_ff, last_k_in;
   logic [IDX_W-1:0]                  k_ff, k_in;
   logic [SAMPLE_BITS-1:0]            peak_ff, peak_in;
   logic                              last_row_ff, last_row_in;
   logic                              neg_ff, neg_in;
   logic [NUM_W-1:0]                  rem_ff, rem_in;
   logic [NUM_W-1:0]                  dsh_ff, dsh_in;
   logic [QB-1:0]                     quot_ff, quot_in;
   logic [2:0]                        step_ff, step_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rdq_pkg::QUANT_BITS-1:0]    rsp_q_ff, rsp_q_in;
   logic [rdq_pkg::PEAK_BITS-1:0]     rsp_peak_ff, rsp_peak_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_mlast_ff, rsp_mlast_in;

   logic                              csr_wr;
   logic                              req_acc;
   logic [CNT_W-1:0]                  eff_len;
   logic [SAMPLE_BITS-1:0]            x_in;
   logic [SAMPLE_BITS-1:0]            x_mag;
   logic [SAMPLE_BITS-1:0]            rd_data;
   logic [SAMPLE_BITS-1:0]            rd_mag;
   logic [NUM_W-1:0]                  rd_mag_w;
   logic                              ram_rd;
   logic [rdq_pkg::ROWS_BITS-1:0]     rows_eff;
   logic [QB-1:0]                     r_val;

   rdq_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (ROW_MAX)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (idx_ff),
      .wr_data (x_in),
      .rd_en   (ram_rd),
      .rd_addr (k_ff),
      .rd_data (rd_data)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign req_tready = (state_ff == S_COLLECT);
   assign req_acc    = req_tvalid & req_tready;
   assign x_in       = req_tdata[SAMPLE_BITS-1:0];
   assign x_mag      = x_in[SAMPLE_BITS-1] ? (~x_in + 1'b1) : x_in;
   assign rd_mag     = rd_data[SAMPLE_BITS-1] ? (~rd_data + 1'b1) : rd_data;
   assign rd_mag_w   = NUM_W'(rd_mag);
   assign ram_rd     = (state_ff == S_READ);
   assign rows_eff   = (row_count_ff == '0) ? rdq_pkg::ROWS_BITS'(1) : row_count_ff;
   assign r_val      = (peak_ff == '0) ? '0 : quot_ff;

   always_comb begin
      if (row_length_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (32'(row_length_ff) > ROW_MAX) begin
         eff_len = CNT_W'(ROW_MAX);
      end else begin
         eff_len = CNT_W'(row_length_ff);
      end
   end

   always_comb begin
      case (csr_paddr[2])
         rdq_pkg::CSR_ROW_LENGTH: csr_prdata = rdq_pkg::CSR_DATA_BITS'(row_length_ff);
         rdq_pkg::CSR_ROW_COUNT:  csr_prdata = rdq_pkg::CSR_DATA_BITS'(row_count_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      row_length_in = row_length_ff;
      row_count_in  = row_count_ff;
      row_idx_in    = row_idx_ff;
      idx_in        = idx_ff;
      last_k_in     = last_k_ff;
      k_in          = k_ff;
      peak_in       = peak_ff;
      last_row_in   = last_row_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_q_in      = rsp_q_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_mlast_in  = rsp_mlast_ff;

      if (csr_wr) begin
         case (csr_paddr[2])
            rdq_pkg::CSR_ROW_LENGTH: row_length_in = csr_pwdata[rdq_pkg::LEN_BITS-1:0];
            rdq_pkg::CSR_ROW_COUNT:  row_count_in  = csr_pwdata[rdq_pkg::ROWS_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_COLLECT: begin
            if (req_acc) begin
               if (x_mag > peak_ff) begin
                  peak_in = x_mag;
               end
               if ((CNT_W'(idx_ff) + CNT_W'(1)) >= eff_len) begin
                  last_k_in   = idx_ff;
                  k_in        = '0;
                  last_row_in = ((17'(row_idx_ff) + 17'd1) >= 17'(rows_eff));
                  row_idx_in  = last_row_in ? '0 : row_idx_ff + 1'b1;
                  state_in    = S_READ;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // dividend 2*127*|x| + peak, divisor 2*peak aligned to the top quotient bit
            neg_in   = rd_data[SAMPLE_BITS-1];
            rem_in   = (rd_mag_w << 8) - (rd_mag_w << 1) + NUM_W'(peak_ff);
            dsh_in   = NUM_W'(peak_ff) << QB;
            quot_in  = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in  = rem_ff - dsh_ff;
               quot_in = {quot_ff[QB-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[QB-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == 3'(QB - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_q_in     = neg_ff ? rdq_pkg::MID_CODE - {1'b0, r_val}
                                     : rdq_pkg::MID_CODE + {1'b0, r_val};
               rsp_peak_in  = rdq_pkg::PEAK_BITS'(peak_ff);
               rsp_last_in  = (k_ff == last_k_ff);
               rsp_mlast_in = (k_ff == last_k_ff) & last_row_ff;
               if (k_ff == last_k_ff) begin
                  peak_in  = '0;
                  idx_in   = '0;
                  state_in = S_COLLECT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_COLLECT;
         row_length_ff <= rdq_pkg::ROW_LENGTH_RESET;
         row_count_ff  <= rdq_pkg::ROW_COUNT_RESET;
         row_idx_ff    <= '0;
         idx_ff        <= '0;
         peak_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_length_ff <= row_length_in;
         row_count_ff  <= row_count_in;
         row_idx_ff    <= row_idx_in;
         idx_ff        <= idx_in;
         peak_ff       <= peak_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      last_k_ff    <= last_k_in;
      k_ff         <= k_in;
      last_row_ff  <= last_row_in;
      neg_ff       <= neg_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quot_ff      <= quot_in;
      step_ff      <= step_in;
      rsp_q_ff     <= rsp_q_in;
      rsp_peak_ff  <= rsp_peak_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_mlast_ff <= rsp_mlast_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_peak_ff, rsp_q_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_mlast_ff;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the row dynamic int8 quantizer core.
module tb;

   localparam int ROW_MAX       = 64;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 390;

   typedef struct packed {
      logic [rdq_pkg::QUANT_BITS-1:0] quant;
      logic [rdq_pkg::PEAK_BITS-1:0]  peak;
      logic                           row_end;
      logic                           matrix_end;
   } quant_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [rdq_pkg::CSR_ADDR_BITS-1:0] csr_paddr  = '0;
   logic [rdq_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [rdq_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic signed [15:0] row_buf [ROW_MAX];
   int                 peak_now;
   int                 fill_pos;
   int                 rows_done;
   logic [rdq_pkg::LEN_BITS-1:0]  cfg_len;
   logic [rdq_pkg::ROWS_BITS-1:0] cfg_rows;
   quant_result_type   quant_due [$];

   int  cycle;
   int  errors;
   int  samples_in;
   int  bytes_checked;
   int  csr_writes;
   bit  steady;
   int  holds_asked;
   int  holds_done;
   int  hold_left;
   int  rx_wait;

   row_dynamic_int8_quantizer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [15:0] sample
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [7:0] quant_byte, [23:8] row_peak
      .rsp_tlast   (rsp_tlast),   // row_last
      .rsp_tuser   (rsp_tuser),   // matrix_last
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d results outstanding", cycle,
                  quant_due.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= 60) $display("tb: mismatch at cycle %0d: %s", cycle, what);
   endtask

   function automatic int row_span();
      if (cfg_len == 0) return 1;
      if (cfg_len > ROW_MAX) return ROW_MAX;
      return int'(cfg_len);
   endfunction

   // round half away from zero of |x|*127/peak, offset by the zero point
   function automatic logic [7:0] scale_to_byte(input logic signed [15:0] x, input int peak);
      longint mag;
      longint r;
      longint q;
      if (peak == 0) return rdq_pkg::MID_CODE;
      mag = (x < 0) ? -longint'(x) : longint'(x);
      r = (2 * mag * 127 + peak) / (2 * longint'(peak));
      q = (x < 0) ? 128 - r : 128 + r;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   function automatic void fold_sample(input logic [15:0] raw);
      logic signed [15:0] x;
      int mag;
      int slot;
      int rows;
      bit last_row;
      quant_result_type r;
      x = $signed(raw);
      mag = (x < 0) ? -int'(x) : int'(x);
      slot = (fill_pos >= ROW_MAX) ? ROW_MAX - 1 : fill_pos;
      row_buf[slot] = x;
      if (mag > peak_now) peak_now = mag;
      if (slot + 1 < row_span()) begin
         fill_pos = slot + 1;
         return;
      end
      rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
      last_row = (rows_done + 1 >= rows);
      for (int k = 0; k <= slot; k++) begin
         r.quant      = scale_to_byte(row_buf[k], peak_now);
         r.peak       = peak_now[15:0];
         r.row_end    = (k == slot);
         r.matrix_end = (k == slot) && last_row;
         quant_due.push_back(r);
      end
      peak_now = 0;
      fill_pos = 0;
      rows_done = last_row ? 0 : ((rows_done + 1) & 16'hFFFF);
   endfunction

   // result checker
   always @(posedge clock) begin
      quant_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (quant_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want = quant_due.pop_front();
            bytes_checked++;
            if (rsp_tdata[7:0] !== want.quant)
               report_mismatch($sformatf("quant_byte %0d, want %0d", rsp_tdata[7:0], want.quant));
            if (rsp_tdata[23:8] !== want.peak)
               report_mismatch($sformatf("row_peak %0d, want %0d", rsp_tdata[23:8], want.peak));
            if (rsp_tlast !== want.row_end)
               report_mismatch($sformatf("row_last %b, want %b", rsp_tlast, want.row_end));
            if (rsp_tuser !== want.matrix_end)
               report_mismatch($sformatf("matrix_last %b, want %b", rsp_tuser, want.matrix_end));
         end
      end
   end

   // result receiver: random stall per item, plus long holds on request
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait    <= 0;
         hold_left  <= 0;
      end else if (holds_asked != holds_done) begin
         holds_done <= holds_asked;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tready && rsp_tvalid) begin
         gap = steady ? 0 : $urandom_range(0, 6);
         rx_wait    <= gap;
         rsp_tready <= (gap == 0);
      end else if (rx_wait > 1) begin
         rx_wait <= rx_wait - 1;
      end else begin
         rx_wait    <= 0;
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_sample(input logic [15:0] s);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      fold_sample(s);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      samples_in++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (quant_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == rdq_pkg::CSR_ROW_LENGTH) cfg_len = value[rdq_pkg::LEN_BITS-1:0];
      else cfg_rows = value[rdq_pkg::ROWS_BITS-1:0];
      csr_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic idx);
      logic [31:0] want;
      want = (idx == rdq_pkg::CSR_ROW_LENGTH) ? 32'(cfg_len) : 32'(cfg_rows);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %0d reads %h, want %h", idx, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_shape(input int len, input int rows);
      csr_write(rdq_pkg::CSR_ROW_LENGTH, 32'(len));
      csr_write(rdq_pkg::CSR_ROW_COUNT, 32'(rows));
      csr_read_check(rdq_pkg::CSR_ROW_LENGTH);
      csr_read_check(rdq_pkg::CSR_ROW_COUNT);
   endtask

   function automatic logic [15:0] draw_sample(input int style, input int ceiling);
      logic [15:0] picks [5];
      picks = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
      case (style)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 2 * ceiling) - ceiling);
         2: return picks[$urandom_range(0, 4)];
         default: return 16'h0000;
      endcase
   endfunction

   task automatic test_register_defaults();
      csr_read_check(rdq_pkg::CSR_ROW_LENGTH);
      csr_read_check(rdq_pkg::CSR_ROW_COUNT);
   endtask

   // full-scale, half-way rounding and all-zero rows
   task automatic test_extreme_rows();
      logic [15:0] rows [4][4];
      rows = '{'{16'h8000, 16'h7FFF, 16'h0000, 16'h0001},
               '{16'h7FFF, 16'h8001, 16'h4000, 16'hC001},
               '{16'h0002, 16'h0001, 16'hFFFF, 16'hFFFE},
               '{16'h0000, 16'h0000, 16'h0000, 16'h0000}};
      set_shape(4, 4);
      foreach (rows[r, c]) send_sample(rows[r][c]);
      drain_results();
   endtask

   // zero length behaves as one, zero count marks every row
   task automatic test_degenerate_lengths();
      set_shape(0, 0);
      send_sample(16'h1234);
      send_sample(16'hEDCC);
      drain_results();
   endtask

   task automatic test_length_cut_mid_row();
      set_shape(127, 2);
      for (int i = 0; i < 5; i++) send_sample(draw_sample(0, 0));
      drain_results();
      csr_write(rdq_pkg::CSR_ROW_LENGTH, 32'd3);
      send_sample(draw_sample(0, 0));
      drain_results();
      csr_write(rdq_pkg::CSR_ROW_LENGTH, 32'd1);
      send_sample(draw_sample(1, 50));
      drain_results();
   endtask

   task automatic test_row_count_lowered();
      set_shape(1, 4);
      for (int i = 0; i < 3; i++) send_sample(draw_sample(0, 0));
      drain_results();
      csr_write(rdq_pkg::CSR_ROW_COUNT, 32'd2);
      for (int i = 0; i < 3; i++) send_sample(draw_sample(0, 0));
      drain_results();
   endtask

   // hold the output for a long stretch so the core stalls its input
   task automatic test_backpressure();
      set_shape(8, 3);
      steady = 1'b1;
      holds_asked <= holds_asked + 1;
      for (int i = 0; i < 24; i++) send_sample(draw_sample(0, 0));
      drain_results();
      steady = 1'b0;
      for (int i = 0; i < 24; i++) send_sample(draw_sample(1, 700));
      drain_results();
   endtask

   task automatic test_random_matrices();
      int target;
      int len;
      int rows;
      int span;
      int nrows;
      int style;
      int ceiling;
      int pick;
      target = samples_in + RANDOM_ITEMS;
      while (samples_in < target) begin
         drain_results();
         pick = $urandom_range(0, 19);
         if (pick <= 13) len = $urandom_range(1, 12);
         else if (pick == 14) len = 0;
         else if (pick == 15) len = 64;
         else if (pick == 16) len = $urandom_range(65, 127);
         else if (pick == 17) len = $urandom_range(13, 63);
         else if (pick == 18) len = 1;
         else len = 127;
         pick = $urandom_range(0, 9);
         if (pick == 0) rows = 0;
         else if (pick == 1) rows = 16'hFFFF;
         else if (pick == 2) rows = $urandom_range(0, 16'hFFFF);
         else rows = $urandom_range(1, 5);
         set_shape(len, rows);
         steady = ($urandom_range(0, 3) == 0);
         span = row_span();
         nrows = (span >= 32) ? 1 : $urandom_range(1, 4);
         for (int r = 0; r < nrows; r++) begin
            pick = $urandom_range(0, 99);
            style = (pick < 50) ? 0 : (pick < 80) ? 1 : (pick < 92) ? 2 : 3;
            ceiling = $urandom_range(1, 300);
            for (int j = 0; j < span; j++) send_sample(draw_sample(style, ceiling));
         end
         // leave a partial row for the next setting to cut short
         if (span > 1 && $urandom_range(0, 5) == 0) begin
            for (int j = $urandom_range(1, span - 1); j > 0; j--) send_sample(draw_sample(0, 0));
         end
      end
      steady = 1'b0;
      drain_results();
   endtask

   initial begin
      cfg_len   = rdq_pkg::ROW_LENGTH_RESET;
      cfg_rows  = rdq_pkg::ROW_COUNT_RESET;
      peak_now  = 0;
      fill_pos  = 0;
      rows_done = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_extreme_rows();
      test_degenerate_lengths();
      test_length_cut_mid_row();
      test_row_count_lowered();
      test_backpressure();
      test_random_matrices();
      drain_results();
      $display("tb: %0d samples in, %0d quantized bytes checked, %0d register writes",
               samples_in, bytes_checked, csr_writes);
      $display("tb: row lengths 0..127, zero and half-way rows, cut rows, %0d-cycle hold",
               LONG_HOLD);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rdq_pkg.sv
rtl/rdq_ram.sv
rtl/row_dynamic_int8_quantizer_core.sv
verif/tb.sv
